FILE: rtl/pmtc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page map with LRU translation cache.
// No dependencies; every other file imports this package.
package pmtc_pkg;

  localparam int TABLE_SLOTS      = 64;
  localparam int CACHE_ENTRIES    = 8;
  localparam int OFFSET_BITS      = 14;
  localparam int PAGE_NUMBER_BITS = 34;
  localparam int FLAG_BITS        = 8;
  localparam int PERM_BITS        = 3;
  localparam int SLOT_W           = $clog2(TABLE_SLOTS);
  localparam int CNT_W            = $clog2(TABLE_SLOTS + 1);
  localparam int CE_W             = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_ADDR_W       = 4;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_UNMAP = 2'd1,
    ACT_XLATE = 2'd2,
    ACT_RSVD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SEGV   = 3'd1,
    ST_DENIED = 3'd2,
    ST_NULL   = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAGE = '0;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load_item;
    logic    cache_touch;
    logic    cache_inval;
    logic    scan_start;
    logic    scan_run;
    logic    table_unmap;
    logic    table_map;
    logic    cache_fill;
    logic    flags_read;
    logic    out_load;
    logic    out_xl;
    status_t out_status;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    action_t act;
    logic    is_null;
    logic    segv;
    logic    chit;
    logic    match;
    logic    scan_end;
    logic    free_any;
    logic    flag_ok;
    logic    out_free;
  } sts_t;

endpackage

FILE: rtl/pmtc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result items.
// Depends on pmtc_pkg for field widths.
interface pmtc_req_if import pmtc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [PAGE_NUMBER_BITS-1:0] page_number;
  logic [OFFSET_BITS-1:0]      page_offset;
  logic [FLAG_BITS-1:0]        map_flags;
  logic [PERM_BITS-1:0]        required_perm;

  modport source (output valid, action, page_number, page_offset, map_flags, required_perm,
                  input ready);
  modport sink   (input valid, action, page_number, page_offset, map_flags, required_perm,
                  output ready);
endinterface

interface pmtc_rsp_if import pmtc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [SLOT_W-1:0]      slot;
  logic [OFFSET_BITS-1:0] offset_out;
  logic [FLAG_BITS-1:0]   page_flags;
  logic                   cache_hit;

  modport source (output valid, status, slot, offset_out, page_flags, cache_hit,
                  input ready);
  modport sink   (input valid, status, slot, offset_out, page_flags, cache_hit,
                  output ready);
endinterface

FILE: rtl/page_map_with_lru_translation_cache.sv
`timescale 1ns / 1ps
// Top level of the page map with LRU translation cache.
// Depends on pmtc_pkg, pmtc_if, pmtc_ctrl and pmtc_dp.
//
// Usage:
//   in_ch  : request items (action, page_number, page_offset, map_flags,
//            required_perm), taken when valid and ready are both high.
//   out_ch : one result item per request (status, slot, offset_out,
//            page_flags, cache_hit); slot/offset/flags/hit are zero unless a
//            translate finishes with status ok.
//   APB    : register 0 (byte address 0) is max_page_number, 34 bits.
// One item is worked on at a time; ready is high only while idle.
// Path from accept to result valid:
//   - null, out-of-range or unused action: check, then the result state
//   - translate hitting the cache: check, flags read, then the result state
//   - map, unmap, translate miss: a table scan of up to 64 entries; the
//     scan reads one page-table entry per cycle from its single read port
//     and stops at the first match.
// The next item can be taken in the cycle after the result loads.
// Reset clears table and cache valid bits, restores LRU ranks to the entry
// index and sets max_page_number to all ones. A stalled receiver holds the
// result in the output register; the next item is still taken meanwhile,
// and its result waits until that register frees.
module page_map_with_lru_translation_cache import pmtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  pmtc_req_if.sink               in_ch,
  pmtc_rsp_if.source             out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [PAGE_NUMBER_BITS-1:0] max_page_r;
  logic                        idle;
  logic                        in_fire;
  cmd_t                        cmd;
  sts_t                        sts;

  // Configuration register: written on the access phase when paddr[3] is 0 (register 0).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_page_r <= '1;
    end else if (psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_MAX_PAGE[CFG_ADDR_W-1])) begin
      max_page_r <= pwdata[PAGE_NUMBER_BITS-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_MAX_PAGE[CFG_ADDR_W-1]) ?
                  CFG_DATA_W'(max_page_r) : '0;

  // Take a new item only when the sequencer is idle.
  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;

  pmtc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .idle    (idle),
    .sts     (sts),
    .cmd     (cmd)
  );

  pmtc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .max_page   (max_page_r),
    .in_action  (in_ch.action),
    .in_page    (in_ch.page_number),
    .in_offs    (in_ch.page_offset),
    .in_mflags  (in_ch.map_flags),
    .in_perm    (in_ch.required_perm),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_slot   (out_ch.slot),
    .out_offs   (out_ch.offset_out),
    .out_flags  (out_ch.page_flags),
    .out_hit    (out_ch.cache_hit)
  );

endmodule

FILE: rtl/pmtc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for map, unmap and translate items.
// Depends on pmtc_pkg; drives pmtc_dp through cmd_t and reads sts_t.
module pmtc_ctrl import pmtc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  output logic idle,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREAD = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    xl_r, xl_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    xl_nxt    = xl_r;
    cmd       = '0;
    cmd.out_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_item = 1'b1;
          xl_nxt        = 1'b0;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.act == ACT_XLATE && sts.is_null) begin
          st_nxt = ST_NULL;  state_nxt = S_RESP;
        end else if (sts.act == ACT_RSVD) begin
          st_nxt = ST_OK;    state_nxt = S_RESP;
        end else if (sts.segv) begin
          st_nxt = ST_SEGV;  state_nxt = S_RESP;
        end else if (sts.act == ACT_XLATE && sts.chit) begin
          cmd.cache_touch = 1'b1;
          state_nxt       = S_FREAD;
        end else begin
          cmd.cache_inval = (sts.act == ACT_UNMAP);
          cmd.scan_start  = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        priority if (sts.match) begin
          st_nxt = ST_OK;
          priority if (sts.act == ACT_UNMAP) begin
            cmd.table_unmap = 1'b1;
            state_nxt       = S_RESP;
          end else if (sts.act == ACT_XLATE) begin
            cmd.cache_fill = 1'b1;
            state_nxt      = S_FREAD;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (sts.scan_end) begin
          state_nxt = S_RESP;
          priority if (sts.act == ACT_MAP) begin
            cmd.table_map = sts.free_any;
            st_nxt        = sts.free_any ? ST_OK : ST_FULL;
          end else if (sts.act == ACT_XLATE) begin
            st_nxt = ST_SEGV;
          end else begin
            st_nxt = ST_OK;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FREAD: begin
        cmd.flags_read = 1'b1;
        xl_nxt         = 1'b1;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_xl     = xl_r;
          cmd.out_status = xl_r ? (sts.flag_ok ? ST_OK : ST_DENIED) : st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
      xl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      xl_r    <= xl_nxt;
    end
  end

endmodule

FILE: rtl/pmtc_dp.sv
`timescale 1ns / 1ps
// Datapath: item registers, page table memories, translation cache, LRU, result register.
// Depends on pmtc_pkg; controlled by pmtc_ctrl.
module pmtc_dp import pmtc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output sts_t                        sts,
  input  logic [PAGE_NUMBER_BITS-1:0] max_page,
  input  logic [1:0]                  in_action,
  input  logic [PAGE_NUMBER_BITS-1:0] in_page,
  input  logic [OFFSET_BITS-1:0]      in_offs,
  input  logic [FLAG_BITS-1:0]        in_mflags,
  input  logic [PERM_BITS-1:0]        in_perm,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [SLOT_W-1:0]           out_slot,
  output logic [OFFSET_BITS-1:0]      out_offs,
  output logic [FLAG_BITS-1:0]        out_flags,
  output logic                        out_hit
);

  // Item registers
  action_t                     act_r;
  logic [PAGE_NUMBER_BITS-1:0] page_r;
  logic [OFFSET_BITS-1:0]      offs_r;
  logic [FLAG_BITS-1:0]        mflags_r;
  logic [PERM_BITS-1:0]        perm_r;
  logic                        hit_r;
  logic [SLOT_W-1:0]           slot_r;

  // Page table
  logic [PAGE_NUMBER_BITS-1:0] page_mem [TABLE_SLOTS];
  logic [FLAG_BITS-1:0]        flags_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]      tvalid_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [PAGE_NUMBER_BITS-1:0] rd_page_r;
  logic [SLOT_W-1:0]           rd_idx_r;
  logic                        rd_vld_r;
  logic [FLAG_BITS-1:0]        rd_flags_r;
  logic                        scan_issue;
  logic [SLOT_W-1:0]           free_idx;

  // Translation cache
  logic                        cvalid_r [CACHE_ENTRIES];
  logic [PAGE_NUMBER_BITS-1:0] cpage_r  [CACHE_ENTRIES];
  logic [SLOT_W-1:0]           cslot_r  [CACHE_ENTRIES];
  logic [CE_W-1:0]             rank_r   [CACHE_ENTRIES];
  logic [CE_W-1:0]             rank_nxt [CACHE_ENTRIES];
  logic [CE_W-1:0]             hit_idx, victim, touch_e, touch_rank;
  logic                        chit, any_free_c;

  // Result register
  logic                        out_valid_r;
  logic [2:0]                  out_status_r;
  logic [SLOT_W-1:0]           out_slot_r;
  logic [OFFSET_BITS-1:0]      out_offs_r;
  logic [FLAG_BITS-1:0]        out_flags_r;
  logic                        out_hit_r;

  assign scan_issue = cmd.scan_run && (cnt_r < CNT_W'(TABLE_SLOTS));

  always_comb begin
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!tvalid_r[i]) free_idx = SLOT_W'(i);
    end
  end

  always_comb begin
    chit    = 1'b0;
    hit_idx = '0;
    for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
      if (cvalid_r[k] && cpage_r[k] == page_r) begin
        chit    = 1'b1;
        hit_idx = CE_W'(k);
      end
    end
  end

  // Victim: lowest invalid entry, else the entry of highest rank.
  always_comb begin
    logic [CE_W-1:0] oldest;
    oldest     = '0;
    victim     = '0;
    any_free_c = 1'b0;
    for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
      if (rank_r[k] == CE_W'(CACHE_ENTRIES - 1)) oldest = CE_W'(k);
      if (!cvalid_r[k]) begin
        any_free_c = 1'b1;
        victim     = CE_W'(k);
      end
    end
    if (!any_free_c) victim = oldest;
  end

  // Move the touched entry to rank 0, age the younger ones.
  always_comb begin
    touch_e    = cmd.cache_fill ? victim : hit_idx;
    touch_rank = rank_r[touch_e];
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      rank_nxt[k] = (rank_r[k] < touch_rank) ? rank_r[k] + CE_W'(1) : rank_r[k];
    end
    rank_nxt[touch_e] = '0;
  end

  always_comb begin
    sts          = '0;
    sts.act      = act_r;
    sts.is_null  = (page_r == '0) && (offs_r == '0);
    sts.segv     = (page_r > max_page);
    sts.chit     = chit;
    sts.match    = rd_vld_r && tvalid_r[rd_idx_r] && (rd_page_r == page_r);
    sts.scan_end = rd_vld_r && (rd_idx_r == SLOT_W'(TABLE_SLOTS - 1));
    sts.free_any = ~&tvalid_r;
    sts.flag_ok  = ((rd_flags_r[PERM_BITS-1:0] & perm_r) == perm_r);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r    <= action_t'(in_action);
      page_r   <= in_page;
      offs_r   <= in_offs;
      mflags_r <= in_mflags;
      perm_r   <= in_perm;
      hit_r    <= 1'b0;
    end
    if (cmd.cache_touch) begin
      hit_r  <= 1'b1;
      slot_r <= cslot_r[hit_idx];
    end
    if (cmd.cache_fill) slot_r <= rd_idx_r;
    if (cmd.table_map) begin
      page_mem[free_idx]  <= page_r;
      flags_mem[free_idx] <= mflags_r;
    end
    if (scan_issue) begin
      rd_page_r <= page_mem[cnt_r[SLOT_W-1:0]];
      rd_idx_r  <= cnt_r[SLOT_W-1:0];
    end
    if (cmd.flags_read) rd_flags_r <= flags_mem[slot_r];
    if (cmd.cache_fill) begin
      cpage_r[victim] <= page_r;
      cslot_r[victim] <= rd_idx_r;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      if (cmd.out_xl && cmd.out_status == ST_OK) begin
        out_slot_r  <= slot_r;
        out_offs_r  <= offs_r;
        out_flags_r <= rd_flags_r;
        out_hit_r   <= hit_r;
      end else begin
        out_slot_r  <= '0;
        out_offs_r  <= '0;
        out_flags_r <= '0;
        out_hit_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r    <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        cvalid_r[k] <= 1'b0;
        rank_r[k]   <= CE_W'(k);
      end
    end else begin
      rd_vld_r <= scan_issue;
      if (cmd.scan_start) cnt_r <= '0;
      else if (scan_issue) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.table_map) tvalid_r[free_idx] <= 1'b1;
      if (cmd.table_unmap) tvalid_r[rd_idx_r] <= 1'b0;
      if (cmd.cache_inval && chit) cvalid_r[hit_idx] <= 1'b0;
      if (cmd.cache_fill) cvalid_r[victim] <= 1'b1;
      if (cmd.cache_touch || cmd.cache_fill) begin
        for (int k = 0; k < CACHE_ENTRIES; k++) rank_r[k] <= rank_nxt[k];
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_offs   = out_offs_r;
  assign out_flags  = out_flags_r;
  assign out_hit    = out_hit_r;

endmodule

FILE: rtl/pmtc_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the page map top level, attached by bind.
// Depends on pmtc_pkg for widths and status codes.
module pmtc_chk import pmtc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       cache_hit,
  input logic       pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_SEGV || status == ST_DENIED ||
                   status == ST_NULL || status == ST_FULL))
    else $error("undefined status code");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cache_hit |-> status == ST_OK)
    else $error("cache hit flagged on failed item");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind page_map_with_lru_translation_cache pmtc_chk u_pmtc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .cache_hit (out_ch.cache_hit),
  .pready    (pready)
);

FILE: sim/page_map_with_lru_translation_cache_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_map_with_lru_translation_cache: directed table plus
// random phases, checked on typed-in results or an in-bench page map/LRU cache model.
// Depends on pmtc_pkg, pmtc_if and the block's RTL.
module page_map_with_lru_translation_cache_test;
  import pmtc_pkg::*;

  localparam int  LIMIT_CYCLES = 1000000;
  localparam int  DRAIN_CYCLES = 80;   // longest scan plus output slack
  localparam int  LONG_HOLD    = 300;
  localparam logic [PAGE_NUMBER_BITS-1:0] PAGE_ALL = '1;

  typedef struct {
    action_t                     action;
    logic [PAGE_NUMBER_BITS-1:0] page;
    logic [OFFSET_BITS-1:0]      offs;
    logic [FLAG_BITS-1:0]        flags;
    logic [PERM_BITS-1:0]        perm;
  } req_t;

  typedef struct {
    status_t                status;
    logic [SLOT_W-1:0]      slot;
    logic [OFFSET_BITS-1:0] offs;
    logic [FLAG_BITS-1:0]   flags;
    logic                   hit;
  } xlat_t;

  // Directed row: request, plus an optional typed-in result.
  typedef struct {
    req_t  req;
    bit    typed;
    xlat_t res;
  } row_t;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  pmtc_req_if in_ch ();
  pmtc_rsp_if out_ch ();

  page_map_with_lru_translation_cache dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow page map and translation cache.
  logic [PAGE_NUMBER_BITS-1:0] max_page;
  logic                        pt_valid [TABLE_SLOTS];
  logic [PAGE_NUMBER_BITS-1:0] pt_page  [TABLE_SLOTS];
  logic [FLAG_BITS-1:0]        pt_flags [TABLE_SLOTS];
  logic                        tc_valid [CACHE_ENTRIES];
  logic [PAGE_NUMBER_BITS-1:0] tc_page  [CACHE_ENTRIES];
  logic [SLOT_W-1:0]           tc_slot  [CACHE_ENTRIES];
  int                          tc_rank  [CACHE_ENTRIES];

  xlat_t pending_xlat[$];
  int    errors;
  int    cycles;

  // Sender side handoff to the monitor: typed result of the item on the bus.
  bit    cur_typed;
  xlat_t cur_res;

  int idle_pct, stall_pct;
  int hold_req;

  // Make cache entry e the most recently used.
  function automatic void promote(int e);
    int r;
    r = tc_rank[e];
    for (int k = 0; k < CACHE_ENTRIES; k++)
      if (tc_rank[k] < r) tc_rank[k]++;
    tc_rank[e] = 0;
  endfunction

  function automatic int find_slot(logic [PAGE_NUMBER_BITS-1:0] p);
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (pt_valid[i] && pt_page[i] == p) return i;
    return -1;
  endfunction

  // Apply one request to the shadow state and return its result.
  function automatic xlat_t resolve_request(req_t r);
    xlat_t res;
    int    s;
    int    e;
    bit    hit;
    bit    found;
    res.status = ST_OK;
    res.slot   = '0;
    res.offs   = '0;
    res.flags  = '0;
    res.hit    = 1'b0;
    hit = 0;
    s = 0;
    case (r.action)
      ACT_MAP: begin
        if (r.page > max_page) begin
          res.status = ST_SEGV;
        end else if (find_slot(r.page) < 0) begin
          res.status = ST_FULL;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!pt_valid[i]) begin
              pt_valid[i] = 1'b1;
              pt_page[i]  = r.page;
              pt_flags[i] = r.flags;
              res.status  = ST_OK;
              break;
            end
          end
        end
      end
      ACT_UNMAP: begin
        if (r.page > max_page) begin
          res.status = ST_SEGV;
        end else begin
          s = find_slot(r.page);
          if (s >= 0) begin
            pt_valid[s] = 1'b0;
            pt_flags[s] = '0;
          end
          // Drop the cached copy; its rank stays where it is.
          for (int k = 0; k < CACHE_ENTRIES; k++) begin
            if (tc_valid[k] && tc_page[k] == r.page) begin
              tc_valid[k] = 1'b0;
              break;
            end
          end
        end
      end
      ACT_XLATE: begin
        if (r.page == '0 && r.offs == '0) begin
          res.status = ST_NULL;
        end else if (r.page > max_page) begin
          res.status = ST_SEGV;
        end else begin
          for (int k = 0; k < CACHE_ENTRIES; k++) begin
            if (tc_valid[k] && tc_page[k] == r.page) begin
              hit = 1;
              s = tc_slot[k];
              promote(k);
              break;
            end
          end
          if (!hit) begin
            s = find_slot(r.page);
            if (s < 0) begin
              res.status = ST_SEGV;
            end else begin
              // Fill the lowest free entry, else evict the oldest.
              e = 0;
              found = 0;
              for (int k = 0; k < CACHE_ENTRIES; k++) begin
                if (!tc_valid[k]) begin
                  e = k;
                  found = 1;
                  break;
                end
              end
              if (!found) begin
                for (int k = 0; k < CACHE_ENTRIES; k++) begin
                  if (tc_rank[k] == CACHE_ENTRIES - 1) begin
                    e = k;
                    break;
                  end
                end
              end
              tc_valid[e] = 1'b1;
              tc_page[e]  = r.page;
              tc_slot[e]  = s[SLOT_W-1:0];
              promote(e);
            end
          end
          // Permission check comes after the fill.
          if (res.status == ST_OK) begin
            if ((pt_flags[s] & {5'b0, r.perm}) != {5'b0, r.perm}) begin
              res.status = ST_DENIED;
            end else begin
              res.slot  = s[SLOT_W-1:0];
              res.offs  = r.offs;
              res.flags = pt_flags[s];
              res.hit   = hit;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("page_map_with_lru_translation_cache_test: errors");
      $finish;
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    req_t  r;
    xlat_t p;
    xlat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        r.action = action_t'(in_ch.action);
        r.page   = in_ch.page_number;
        r.offs   = in_ch.page_offset;
        r.flags  = in_ch.map_flags;
        r.perm   = in_ch.required_perm;
        p = resolve_request(r);
        pending_xlat.push_back(cur_typed ? cur_res : p);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_xlat.size() == 0) begin
          $error("result with nothing expected: status %0d", out_ch.status);
          errors++;
        end else begin
          want = pending_xlat.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            errors++;
          end
          if (out_ch.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
            errors++;
          end
          if (out_ch.offset_out !== want.offs) begin
            $error("offset_out: expected %h, got %h", want.offs, out_ch.offset_out);
            errors++;
          end
          if (out_ch.page_flags !== want.flags) begin
            $error("page_flags: expected %h, got %h", want.flags, out_ch.page_flags);
            errors++;
          end
          if (out_ch.cache_hit !== want.hit) begin
            $error("cache_hit: expected %0d, got %0d", want.hit, out_ch.cache_hit);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one request; return once it has been accepted.
  task automatic offer_request(req_t r, bit typed, xlat_t res);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cur_typed <= typed;
    cur_res   <= res;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= r.action;
    in_ch.page_number   <= r.page;
    in_ch.page_offset   <= r.offs;
    in_ch.map_flags     <= r.flags;
    in_ch.required_perm <= r.perm;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the request side low until every result is back, then let the block settle.
  task automatic drain_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_page(logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= REG_MAX_PAGE; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_page = v[PAGE_NUMBER_BITS-1:0];
    // Read back with a setup phase, then an access phase.
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[PAGE_NUMBER_BITS-1:0] !== max_page) begin
      $error("max_page_number: expected %h, got %h", max_page, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic req_t random_request(logic [PAGE_NUMBER_BITS-1:0] pool_base, int pool_n);
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    r.action = (pick < 30) ? ACT_MAP : (pick < 45) ? ACT_UNMAP :
               (pick < 97) ? ACT_XLATE : ACT_RSVD;
    pick = $urandom_range(99);
    if (pick < 85)
      r.page = pool_base + PAGE_NUMBER_BITS'($urandom_range(pool_n - 1));
    else if (pick < 92) r.page = {2'($urandom_range(3)), $urandom};
    else if (pick < 96) r.page = '0;
    else                r.page = PAGE_ALL;
    r.offs  = ($urandom_range(9) == 0) ? '0 : OFFSET_BITS'($urandom);
    r.flags = FLAG_BITS'($urandom);
    r.perm  = ($urandom_range(9) < 3) ? '0 : PERM_BITS'($urandom);
    return r;
  endfunction

  function automatic row_t mk_row(action_t a, logic [PAGE_NUMBER_BITS-1:0] p,
                                  logic [OFFSET_BITS-1:0] o, logic [FLAG_BITS-1:0] f,
                                  logic [PERM_BITS-1:0] pm, bit typed, status_t st,
                                  int sl, logic [OFFSET_BITS-1:0] ro,
                                  logic [FLAG_BITS-1:0] rf, bit rh);
    row_t w;
    w.req.action = a; w.req.page = p; w.req.offs = o; w.req.flags = f; w.req.perm = pm;
    w.typed = typed;
    w.res.status = st; w.res.slot = sl[SLOT_W-1:0]; w.res.offs = ro;
    w.res.flags = rf; w.res.hit = rh;
    return w;
  endfunction

  row_t directed[$];

  // Per-phase knobs: limit, page pool, idling, stalls and size.
  logic [CFG_DATA_W-1:0]       ph_max  [5];
  logic [PAGE_NUMBER_BITS-1:0] ph_base [5];
  int                          ph_pool [5];
  int                          ph_idle [5];
  int                          ph_stall[5];
  int                          ph_items[5];

  initial begin
    req_t r;
    xlat_t none;
    none.status = ST_OK; none.slot = '0; none.offs = '0; none.flags = '0; none.hit = 1'b0;
    errors = 0; hold_req = 0; idle_pct = 0; stall_pct = 0;
    cur_typed = 0; cur_res = none;
    max_page = PAGE_ALL;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      pt_valid[i] = 1'b0; pt_page[i] = '0; pt_flags[i] = '0;
    end
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      tc_valid[k] = 1'b0; tc_page[k] = '0; tc_slot[k] = '0; tc_rank[k] = k;
    end
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.action = ACT_MAP; in_ch.page_number = '0;
    in_ch.page_offset = '0; in_ch.map_flags = '0; in_ch.required_perm = '0;

    // Directed part, against the reset limit of all ones.
    directed.push_back(mk_row(ACT_XLATE, '0, '0, 8'h00, 3'd0, 1, ST_NULL, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_XLATE, '0, 14'd5, 8'h00, 3'd0, 1, ST_SEGV, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_MAP, PAGE_ALL, '0, 8'hFF, 3'd0, 1, ST_OK, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_XLATE, PAGE_ALL, 14'h3FFF, 8'h00, 3'd7, 1, ST_OK,
                              0, 14'h3FFF, 8'hFF, 0));
    directed.push_back(mk_row(ACT_XLATE, PAGE_ALL, 14'h3FFF, 8'h00, 3'd7, 1, ST_OK,
                              0, 14'h3FFF, 8'hFF, 1));
    directed.push_back(mk_row(ACT_MAP, 34'd5, '0, 8'h01, 3'd0, 1, ST_OK, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_MAP, 34'd5, '0, 8'h07, 3'd0, 1, ST_OK, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_XLATE, 34'd5, 14'h123, 8'h00, 3'd2, 1, ST_DENIED,
                              0, 0, 0, 0));
    directed.push_back(mk_row(ACT_XLATE, 34'd5, 14'h123, 8'h00, 3'd1, 1, ST_OK,
                              1, 14'h123, 8'h01, 1));
    directed.push_back(mk_row(ACT_UNMAP, 34'd5, '0, 8'h00, 3'd0, 1, ST_OK, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_XLATE, 34'd5, 14'h1, 8'h00, 3'd0, 1, ST_SEGV, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_UNMAP, 34'd7, '0, 8'h00, 3'd0, 1, ST_OK, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_RSVD, 34'h2AAAAAAAA, 14'h2AAA, 8'hAA, 3'd5, 1, ST_OK,
                              0, 0, 0, 0));
    directed.push_back(mk_row(ACT_MAP, '0, '0, 8'h00, 3'd0, 1, ST_OK, 0, 0, 0, 0));
    directed.push_back(mk_row(ACT_XLATE, '0, 14'd1, 8'h00, 3'd0, 1, ST_OK, 1, 14'd1, 0, 0));
    // Fill the cache past its size so the oldest entries get evicted.
    for (int i = 0; i < 9; i++)
      directed.push_back(mk_row(ACT_MAP, 34'd100 + PAGE_NUMBER_BITS'(i), '0,
                                8'h80 | FLAG_BITS'(i), 3'd0, 0, ST_OK, 0, 0, 0, 0));
    for (int i = 0; i < 10; i++)
      directed.push_back(mk_row(ACT_XLATE, 34'd100 + PAGE_NUMBER_BITS'(i % 9), 14'h155,
                                8'h00, 3'd0, 0, ST_OK, 0, 0, 0, 0));

    ph_max[0] = '1;            ph_base[0] = '0;
    ph_pool[0] = 100; ph_idle[0] = 0;  ph_stall[0] = 0;  ph_items[0] = 300;
    ph_max[1] = 64'd40;        ph_base[1] = '0;
    ph_pool[1] = 60;  ph_idle[1] = 75; ph_stall[1] = 0;  ph_items[1] = 250;
    ph_max[2] = 64'h3FFFFFFFF; ph_base[2] = 34'h3FFFFFF80;
    ph_pool[2] = 128; ph_idle[2] = 0;  ph_stall[2] = 75; ph_items[2] = 250;
    ph_max[3] = 64'd0;         ph_base[3] = '0;
    ph_pool[3] = 4;   ph_idle[3] = 27; ph_stall[3] = 27; ph_items[3] = 60;
    ph_max[4] = 64'h200000000; ph_base[4] = 34'h1FFFFFFE0;
    ph_pool[4] = 64;  ph_idle[4] = 27; ph_stall[4] = 27; ph_items[4] = 300;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) offer_request(directed[i].req, directed[i].typed, directed[i].res);
    drain_block();

    for (int ph = 0; ph < 5; ph++) begin
      write_max_page(ph_max[ph]);
      idle_pct  = ph_idle[ph];
      stall_pct = ph_stall[ph];
      for (int n = 0; n < ph_items[ph]; n++) begin
        // Back up the block with the receiver held off, then let it drain fully.
        if (ph == 0 && n == 100) hold_req++;
        if (ph == 0 && n == 150) drain_block();
        r = random_request(ph_base[ph], ph_pool[ph]);
        offer_request(r, 0, none);
      end
      drain_block();
    end

    if (errors == 0) begin
      $display("page_map_with_lru_translation_cache_test: clean");
    end else begin
      $display("page_map_with_lru_translation_cache_test: errors");
    end
    $finish;
  end

endmodule
